// File: rtl/tds_pkg.sv
// shared types, constants and helpers of the timer divider search block
package tds_pkg;

    // datapath and field widths
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned MSEL_W   = 2;
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned NUM_MULT = 4;

    // limits of the output fields
    localparam int unsigned PERIOD_FIELD_MAX = 65535;
    localparam int unsigned SHIFT_FIELD_MAX  = 7;

    // parameter defaults
    localparam int unsigned MAX_PERIOD_DEF         = 65535;
    localparam int unsigned MAX_PRESCALE_SHIFT_DEF = 7;

    // register map
    localparam int unsigned ADDR_W = 2;
    localparam logic [ADDR_W-1:0] REG_SOURCE_CLOCK_ADDR = 2'd0;
    localparam logic [DATA_W-1:0] SOURCE_CLOCK_RESET = 32'd48000000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE_START,
        ST_BASE_WAIT,
        ST_PER_START,
        ST_PER_WAIT,
        ST_DONE
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    // answer of the shared divider
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    // clock multipliers tried in order
    function automatic logic [DATA_W-1:0] mult_value(input logic [MSEL_W-1:0] sel);
        logic [DATA_W-1:0] v;
        case (sel)
            2'd0:    v = 32'd1;
            2'd1:    v = 32'd10;
            2'd2:    v = 32'd20;
            default: v = 32'd40;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/timer_divider_search.sv
// top level of the timer prescaler and period search block
//
// Usage: program the source clock in hertz through the APB port at byte
// address 0 (reset value 48000000), then send a wanted frequency as one input
// item on i_in_valid / o_in_stall. One result item (status, multiplier index,
// prescale shift, period) comes back on o_out_valid / i_out_stall.
// Every division runs on one shared serial divider at one quotient bit per
// cycle. An item needs one division of the clock per multiplier tried and
// one per prescale shift tried: between 2 and 36 divisions.
// A zero target skips all divisions; its error result is valid in the cycle
// after acceptance.
// One item is worked on at a time; o_in_stall stays high from acceptance
// until the result has been taken. The result is held in output registers
// for as long as i_out_stall is high. Reset (i_rst_n low at a clock edge)
// returns the sequencer to idle, drops any item in flight and restores the
// source clock register.
module timer_divider_search #(
    parameter int unsigned MAX_PERIOD         = tds_pkg::MAX_PERIOD_DEF,
    parameter int unsigned MAX_PRESCALE_SHIFT = tds_pkg::MAX_PRESCALE_SHIFT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tds_pkg::ADDR_W-1:0]    paddr,
    input  logic [tds_pkg::DATA_W-1:0]    pwdata,
    output logic [tds_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tds_pkg::DATA_W-1:0]    i_target_freq_hz,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic [tds_pkg::MSEL_W-1:0]    o_multiplier_select,
    output logic [tds_pkg::SHIFT_W-1:0]   o_prescale_shift,
    output logic [tds_pkg::PERIOD_W-1:0]  o_period_count
);

    logic [tds_pkg::DATA_W-1:0] r_source_clock_hz;
    logic                       cfg_wr;
    tds_pkg::t_div_req          div_req;
    tds_pkg::t_div_rsp          div_rsp;

    // register write and read decode
    always_comb begin
        pready = 1'b1;
        cfg_wr = psel && penable && pwrite && pready;
        prdata = (paddr == tds_pkg::REG_SOURCE_CLOCK_ADDR) ? r_source_clock_hz : '0;
    end

    // source clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_clock_hz <= tds_pkg::SOURCE_CLOCK_RESET;
        end else if (cfg_wr && paddr == tds_pkg::REG_SOURCE_CLOCK_ADDR) begin
            r_source_clock_hz <= pwdata;
        end
    end

    // search sequencer
    tds_seq #(
        .MAX_PERIOD         (MAX_PERIOD),
        .MAX_PRESCALE_SHIFT (MAX_PRESCALE_SHIFT)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_clock_hz          (r_source_clock_hz),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_target_freq_hz    (i_target_freq_hz),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_multiplier_select (o_multiplier_select),
        .o_prescale_shift    (o_prescale_shift),
        .o_period_count      (o_period_count),
        .o_div_req           (div_req),
        .i_div_rsp           (div_rsp)
    );

    // shared serial divider
    tds_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

// File: rtl/tds_divider.sv
// shared bit-serial restoring divider, one quotient bit per cycle
module tds_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tds_pkg::t_div_req i_req,
    output tds_pkg::t_div_rsp o_rsp
);

    localparam int unsigned W     = tds_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_divisor;

    logic [W:0] rem_shift;
    logic [W:0] diff;
    logic       fits;

    // trial subtract of the shifted partial remainder
    always_comb begin
        rem_shift = {r_rem, r_quo[W-1]};
        diff      = rem_shift - {1'b0, r_divisor};
        fits      = !diff[W];
    end

    // control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[W-1:0] : rem_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/tds_seq.sv
// sequencer that walks multipliers and prescale shifts over the shared divider
module tds_seq #(
    parameter int unsigned MAX_PERIOD         = tds_pkg::MAX_PERIOD_DEF,
    parameter int unsigned MAX_PRESCALE_SHIFT = tds_pkg::MAX_PRESCALE_SHIFT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tds_pkg::DATA_W-1:0]     i_clock_hz,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tds_pkg::DATA_W-1:0]     i_target_freq_hz,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_status,
    output logic [tds_pkg::MSEL_W-1:0]     o_multiplier_select,
    output logic [tds_pkg::SHIFT_W-1:0]    o_prescale_shift,
    output logic [tds_pkg::PERIOD_W-1:0]   o_period_count,
    output tds_pkg::t_div_req              o_div_req,
    input  tds_pkg::t_div_rsp              i_div_rsp
);

    // limits actually used, clipped to the output field ranges
    localparam int unsigned PLIM = (MAX_PERIOD > tds_pkg::PERIOD_FIELD_MAX) ?
                                   tds_pkg::PERIOD_FIELD_MAX : MAX_PERIOD;
    localparam int unsigned SLIM = (MAX_PRESCALE_SHIFT > tds_pkg::SHIFT_FIELD_MAX) ?
                                   tds_pkg::SHIFT_FIELD_MAX : MAX_PRESCALE_SHIFT;
    localparam logic [tds_pkg::DATA_W-1:0]  PLIM_V = tds_pkg::DATA_W'(PLIM);
    localparam logic [tds_pkg::SHIFT_W-1:0] SLIM_V = tds_pkg::SHIFT_W'(SLIM);
    localparam logic [tds_pkg::MSEL_W-1:0]  MLAST  = tds_pkg::MSEL_W'(tds_pkg::NUM_MULT - 1);

    tds_pkg::t_state r_state;
    tds_pkg::t_state n_state;

    logic [tds_pkg::DATA_W-1:0]   r_target;
    logic [tds_pkg::DATA_W-1:0]   r_base;
    logic [tds_pkg::MSEL_W-1:0]   r_m;
    logic [tds_pkg::SHIFT_W-1:0]  r_s;
    logic                         r_status;
    logic [tds_pkg::MSEL_W-1:0]   r_msel;
    logic [tds_pkg::SHIFT_W-1:0]  r_shift;
    logic [tds_pkg::PERIOD_W-1:0] r_period;

    logic accept;
    logic per_fits;
    logic per_nonzero;
    logic s_last;
    logic m_last;

    // decisions on the current trial
    always_comb begin
        accept      = i_in_valid && (r_state == tds_pkg::ST_IDLE);
        per_fits    = i_div_rsp.quotient <= PLIM_V;
        per_nonzero = i_div_rsp.quotient != '0;
        s_last      = r_s == SLIM_V;
        m_last      = r_m == MLAST;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tds_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_target_freq_hz == '0) ? tds_pkg::ST_DONE
                                                       : tds_pkg::ST_BASE_START;
                end
            end
            tds_pkg::ST_BASE_START: n_state = tds_pkg::ST_BASE_WAIT;
            tds_pkg::ST_BASE_WAIT: begin
                if (i_div_rsp.done) n_state = tds_pkg::ST_PER_START;
            end
            tds_pkg::ST_PER_START: n_state = tds_pkg::ST_PER_WAIT;
            tds_pkg::ST_PER_WAIT: begin
                if (i_div_rsp.done) begin
                    if (per_fits && per_nonzero) begin
                        n_state = tds_pkg::ST_DONE;
                    end else if (per_fits || s_last) begin
                        n_state = m_last ? tds_pkg::ST_DONE : tds_pkg::ST_BASE_START;
                    end else begin
                        n_state = tds_pkg::ST_PER_START;
                    end
                end
            end
            tds_pkg::ST_DONE: begin
                if (!i_out_stall) n_state = tds_pkg::ST_IDLE;
            end
            default: n_state = tds_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // outputs and divider requests
    always_comb begin
        o_in_stall  = r_state != tds_pkg::ST_IDLE;
        o_out_valid = r_state == tds_pkg::ST_DONE;
        o_div_req   = '0;
        unique case (r_state)
            tds_pkg::ST_BASE_START: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = i_clock_hz;
                o_div_req.divisor  = tds_pkg::mult_value(r_m);
            end
            tds_pkg::ST_PER_START: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = r_base >> r_s;
                o_div_req.divisor  = r_target;
            end
            default: o_div_req = '0;
        endcase
    end

    // search registers and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target <= i_target_freq_hz;
            r_m      <= '0;
            r_s      <= '0;
            r_status <= 1'b1;
            r_msel   <= '0;
            r_shift  <= '0;
            r_period <= '0;
        end else if (r_state == tds_pkg::ST_BASE_WAIT && i_div_rsp.done) begin
            r_base <= i_div_rsp.quotient;
            r_s    <= '0;
        end else if (r_state == tds_pkg::ST_PER_WAIT && i_div_rsp.done) begin
            if (per_fits && per_nonzero) begin
                r_status <= 1'b0;
                r_msel   <= r_m;
                r_shift  <= r_s;
                r_period <= i_div_rsp.quotient[tds_pkg::PERIOD_W-1:0];
            end else if (per_fits || s_last) begin
                r_m <= r_m + 1'b1;
            end else begin
                r_s <= r_s + 1'b1;
            end
        end
    end

    assign o_status            = r_status;
    assign o_multiplier_select = r_msel;
    assign o_prescale_shift    = r_shift;
    assign o_period_count      = r_period;

`ifndef SYNTHESIS
    // divider answers only while the sequencer waits for one
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == tds_pkg::ST_BASE_WAIT ||
                            r_state == tds_pkg::ST_PER_WAIT))
        else $error("divider done outside a wait state");

    // a zero target goes straight to an error result
    a_zero_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_target_freq_hz == '0) |=> (o_out_valid && o_status))
        else $error("zero target not flagged");

    // a successful result never carries a zero period
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |-> (o_period_count != '0))
        else $error("success with zero period");

    // an error result carries zero settings
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_multiplier_select == '0 &&
                                       o_prescale_shift == '0 &&
                                       o_period_count == '0))
        else $error("error result with nonzero settings");
`endif

endmodule
